// ----- src/lbr_pkg.sv -----
package lbr_pkg;

   localparam int STORE_BYTES    = 4096;
   localparam int MAX_FIELD_BITS = 32;
   localparam int BANKS          = 8;
   localparam int BANK_ROWS      = STORE_BYTES / BANKS;
   localparam int BANK_W         = $clog2(BANKS);
   localparam int ROW_W          = $clog2(BANK_ROWS);
   localparam int WIN_BYTES      = MAX_FIELD_BITS / 8 + 1;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int VAL_W   = 32;
   localparam int POS_W   = 16;
   localparam int COUNT_W = 13;
   localparam int IDX_W   = POS_W - 3;

   localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIELD   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BIT     = 3'd4;

   typedef struct packed {
      logic append;
      logic restart;
      logic launch;
      logic exec;
   } lbr_cmd_type;

endpackage

// ----- src/lbr_ctrl.sv -----
module lbr_ctrl
   import lbr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             busy,
   output lbr_cmd_type      dp_cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign busy   = (state_ff == ST_EXEC);
   assign accept = start && !busy;

   always_comb begin
      dp_cmd.append  = accept && (req_cmd == CMD_APPEND);
      dp_cmd.restart = accept && (req_cmd == CMD_RESTART);
      dp_cmd.launch  = accept && (req_cmd inside {CMD_PEEK, CMD_FIELD, CMD_BIT});
      dp_cmd.exec    = (state_ff == ST_EXEC);
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = dp_cmd.launch ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/lbr_dp.sv -----
module lbr_dp
   import lbr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  lbr_cmd_type       dp_cmd,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic [LEN_W-1:0]  req_field_len,
   input  logic              csr_write_en,
   input  logic [POS_W-1:0]  csr_write_data,
   output logic              rsp_valid,
   output logic [VAL_W-1:0]  rsp_field_value,
   output logic              rsp_more_data,
   output logic [POS_W-1:0]  rsp_bit_position
);

   logic [BYTE_W-1:0]  mem_bank [BANKS][BANK_ROWS];
   logic [BYTE_W-1:0]  rd_ff [BANKS];
   logic [ROW_W-1:0]   rd_row [BANKS];

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [POS_W-1:0]   cursor_ff;
   logic [POS_W-1:0]   cursor_in;
   logic [POS_W-1:0]   limit_ff;
   logic [CMD_W-1:0]   op_ff;
   logic [LEN_W-1:0]   len_ff;

   logic               valid_ff;
   logic [VAL_W-1:0]   value_ff;
   logic [VAL_W-1:0]   value_in;
   logic               more_ff;
   logic               more_in;
   logic [POS_W-1:0]   pos_ff;

   logic [IDX_W-1:0]   cur_idx;
   logic               store_full;
   logic [WIN_BYTES*BYTE_W-1:0] window;
   logic [WIN_BYTES*BYTE_W-1:0] shifted;
   logic [VAL_W:0]     len_mask;
   logic               reached;
   logic               reached_next;
   logic [LEN_W-1:0]   len_cap;
   logic [LEN_W-1:0]   eff_len;
   logic               advancing;
   logic [POS_W:0]     pos_sum;
   logic [IDX_W:0]     padded;

   assign cur_idx    = cursor_ff[POS_W-1:3];
   assign store_full = (count_ff >= COUNT_W'(STORE_BYTES));

   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         rd_row[b] = cur_idx[ROW_W+BANK_W-1:BANK_W]
                   + ROW_W'(BANK_W'(b) < cur_idx[BANK_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < BANKS; b++) begin
         if (dp_cmd.append && !store_full && (count_ff[BANK_W-1:0] == BANK_W'(b))) begin
            mem_bank[b][count_ff[ROW_W+BANK_W-1:BANK_W]] <= req_byte_in;
         end
         if (dp_cmd.launch) begin
            rd_ff[b] <= mem_bank[b][rd_row[b]];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < WIN_BYTES; k++) begin
         if (({1'b0, cur_idx} + (IDX_W+1)'(k)) < (IDX_W+1)'(count_ff)) begin
            window[k*BYTE_W +: BYTE_W] = rd_ff[cur_idx[BANK_W-1:0] + BANK_W'(k)];
         end else begin
            window[k*BYTE_W +: BYTE_W] = '0;
         end
      end
   end

   assign shifted = window >> cursor_ff[2:0];
   assign reached = (limit_ff != '0) && (cursor_ff >= limit_ff);
   assign len_cap = (len_ff > LEN_W'(MAX_FIELD_BITS)) ? LEN_W'(MAX_FIELD_BITS) : len_ff;

   always_comb begin
      case (op_ff)
         CMD_BIT: eff_len = reached ? '0 : LEN_W'(1);
         default: eff_len = len_cap;
      endcase
   end

   assign len_mask  = ~({(VAL_W+1){1'b1}} << eff_len);
   assign value_in  = shifted[VAL_W-1:0] & len_mask[VAL_W-1:0];
   assign advancing = (op_ff == CMD_FIELD) || (op_ff == CMD_BIT);
   assign pos_sum   = {1'b0, cursor_ff} + (POS_W+1)'(eff_len);

   always_comb begin
      if (!advancing || (eff_len == '0) || reached) begin
         cursor_in = cursor_ff;
      end else if ((limit_ff != '0) && (pos_sum > {1'b0, limit_ff})) begin
         cursor_in = limit_ff;
      end else if (pos_sum[POS_W]) begin
         cursor_in = '1;
      end else begin
         cursor_in = pos_sum[POS_W-1:0];
      end
   end

   assign padded       = ((IDX_W+1)'(count_ff) + (IDX_W+1)'(3)) & ~(IDX_W+1)'(3);
   assign reached_next = (limit_ff != '0) && (cursor_in >= limit_ff);
   assign more_in      = !reached_next && ({1'b0, cursor_in[POS_W-1:3]} < padded);

   always_comb begin
      count_in = count_ff;
      if (dp_cmd.restart) begin
         count_in = '0;
      end else if (dp_cmd.append && !store_full) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         limit_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= dp_cmd.exec;
         if (dp_cmd.restart) begin
            cursor_ff <= '0;
         end else if (dp_cmd.exec) begin
            cursor_ff <= cursor_in;
         end
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.launch) begin
         op_ff  <= req_cmd;
         len_ff <= req_field_len;
      end
      if (dp_cmd.exec) begin
         value_ff <= value_in;
         more_ff  <= more_in;
         pos_ff   <= cursor_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_field_value  = value_ff;
   assign rsp_more_data    = more_ff;
   assign rsp_bit_position = pos_ff;

endmodule

// ----- src/lsb_first_bit_reader.sv -----
// Byte store of 4096 bytes read through an LSB-first bit cursor. Append and
// restart requests never raise busy. A peek, field read or bit read first
// does a registered read of a five-byte window from the eight byte-wide
// store banks, then extracts the bits and, for field and bit reads, moves
// the cursor, with busy high during extraction. The result then sits on the
// rsp_ ports for exactly one cycle, marked by rsp_valid, and must be taken
// then, since the receiver cannot stall it. A new request may be started in
// that same cycle; no read is taken while busy is high.
module lsb_first_bit_reader
   import lbr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic [LEN_W-1:0]  req_field_len,
   input  logic              csr_write_en,
   input  logic [POS_W-1:0]  csr_write_data,
   output logic              rsp_valid,
   output logic [VAL_W-1:0]  rsp_field_value,
   output logic              rsp_more_data,
   output logic [POS_W-1:0]  rsp_bit_position
);

   lbr_cmd_type dp_cmd;

   lbr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .busy    (busy),
      .dp_cmd  (dp_cmd)
   );

   lbr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .req_cmd          (req_cmd),
      .req_byte_in      (req_byte_in),
      .req_field_len    (req_field_len),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_field_value  (rsp_field_value),
      .rsp_more_data    (rsp_more_data),
      .rsp_bit_position (rsp_bit_position)
   );

endmodule

// ----- src/lbr_checker.sv -----
module lbr_checker
   import lbr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [CMD_W-1:0]  req_cmd,
   input logic              rsp_valid
);

   logic read_accept;

   assign read_accept = start && !busy && (req_cmd inside {CMD_PEEK, CMD_FIELD, CMD_BIT});

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      read_accept |=> busy)
      else $error("read request did not raise busy");

   a_busy_short: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("no result after busy cycle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

endmodule

bind lsb_first_bit_reader lbr_checker u_lbr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_cmd   (req_cmd),
   .rsp_valid (rsp_valid)
);
